// ===== src/rapid_buffer_flux_assert.svh =====
// Assertion macros used by the checker module of this block.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef RAPID_BUFFER_FLUX_ASSERT_SVH
`define RAPID_BUFFER_FLUX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBF_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("rapid_buffer_flux: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBF_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("rapid_buffer_flux: next-cycle check failed");

`endif

// ===== src/rbf_pkg.sv =====
package rbf_pkg;

    localparam int CONC_W   = 32;
    localparam int RATE_W   = 32;
    localparam int BETA_W   = 25;
    localparam int CFG_AW   = 3;
    localparam int TERM_W   = 59;

    localparam logic [CFG_AW-1:0] REG_LOW_TOTAL  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LOW_KD     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_HIGH_TOTAL = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HIGH_KD    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CYTO_TOTAL = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CYTO_KD    = 3'd5;

    localparam logic [CONC_W-1:0] KD_RESET  = 32'd16777216;
    localparam logic [BETA_W-1:0] ONE_Q24   = 25'd16777216;
    localparam logic [TERM_W-1:0] SUM_LIMIT = 59'h400_0000_0000_0000;

    typedef struct packed {
        logic        [CONC_W-1:0] calcium_conc;
        logic signed [RATE_W-1:0] calcium_rate;
        logic signed [RATE_W-1:0] bound_rate;
    } in_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] buffer_flux;
        logic        [BETA_W-1:0] beta_factor;
    } out_t;

endpackage

// ===== src/rbf_div.sv =====
module rbf_div #(
    parameter int NW = 64,
    parameter int DW = 33
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    // One restoring step per stage. The numerator shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] rem_reg [NW-1];
    logic [DW-1:0] den_reg [NW-1];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] num_in;
        logic [DW:0]   trial;
        logic          take;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = den;
            assign num_in = num;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign num_in = num_reg[i-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[i] <= {num_in[NW-2:0], take};
            end
        end

        if (i < NW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quo = num_reg[NW-1];

endmodule

// ===== src/rapid_buffer_flux.sv =====
// Rapid-buffering flux unit: takes one item per clock while s_ready is high and
// returns one result per item, in order. Results pass through two restoring
// dividers of one quotient bit per stage, 64 stages for the per-buffer quotients
// and 58 stages for beta, plus eight stages of input, multiply, sum, rounding and
// output registers. A two-entry output (register plus skid) lets the input keep
// taking items after the result side stalls, until the skid entry fills.
// Configuration writes take effect at once; the user must make them only while no
// item is in flight, as the block itself does not enforce this.
module rapid_buffer_flux
    import rbf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CONC_W-1:0] cfg_wdata
);

    localparam int NBUF        = 3;
    localparam int DEN_W       = CONC_W + 1;
    localparam int DIFF_W      = RATE_W + 1;
    localparam int DIV1_NW     = 2 * CONC_W;
    localparam int PROD_W      = CONC_W + DEN_W;
    localparam int BDEN_W      = TERM_W;
    localparam int BNUM_W      = TERM_W - 1;
    localparam int FPROD_W     = BETA_W + DIFF_W;
    localparam int FQ_W        = FPROD_W - 24;

    localparam logic [BDEN_W-1:0] ONE_Q32   = BDEN_W'(64'h1_0000_0000);
    localparam logic [BNUM_W-1:0] ONE_Q56   = BNUM_W'(64'h100_0000_0000_0000);
    localparam logic [FPROD_W-1:0] HALF_Q24 = FPROD_W'(32'h80_0000);
    localparam logic [FQ_W-1:0] POS_MAX     = FQ_W'(32'h7FFF_FFFF);
    localparam logic [FQ_W-1:0] NEG_MAX     = FQ_W'(33'h8000_0000);

    // Configuration registers.
    logic [CONC_W-1:0] total_reg [NBUF];
    logic [CONC_W-1:0] kd_reg    [NBUF];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NBUF; b++) begin
                total_reg[b] <= '0;
                kd_reg[b]    <= KD_RESET;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LOW_TOTAL:  total_reg[0] <= cfg_wdata;
                REG_LOW_KD:     kd_reg[0]    <= cfg_wdata;
                REG_HIGH_TOTAL: total_reg[1] <= cfg_wdata;
                REG_HIGH_KD:    kd_reg[1]    <= cfg_wdata;
                REG_CYTO_TOTAL: total_reg[2] <= cfg_wdata;
                REG_CYTO_KD:    kd_reg[2]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Input stage. A zero denominator only happens with zero calcium and zero Kd;
    // feeding 0/1 to the dividers makes that buffer's term come out as zero.
    logic                     s0_valid_reg;
    logic signed [DIFF_W-1:0] s0_diff_reg;
    logic [DEN_W-1:0]         s0_den_reg  [NBUF];
    logic [DIV1_NW-1:0]       s0_pnum_reg [NBUF];
    logic [DIV1_NW-1:0]       s0_qnum_reg [NBUF];

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_diff_reg <= DIFF_W'(s_data.calcium_rate) - DIFF_W'(s_data.bound_rate);
            for (int b = 0; b < NBUF; b++) begin
                logic [DEN_W-1:0] sum;
                sum = {1'b0, s_data.calcium_conc} + {1'b0, kd_reg[b]};
                if (sum == '0) begin
                    s0_den_reg[b]  <= DEN_W'(1);
                    s0_pnum_reg[b] <= '0;
                end else begin
                    s0_den_reg[b]  <= sum;
                    s0_pnum_reg[b] <= {total_reg[b], {CONC_W{1'b0}}};
                end
                s0_qnum_reg[b] <= {kd_reg[b], {CONC_W{1'b0}}};
            end
        end
    end

    logic [DIV1_NW-1:0] p_quo [NBUF];
    logic [DIV1_NW-1:0] q_quo [NBUF];

    for (genvar b = 0; b < NBUF; b++) begin : g_buf
        rbf_div #(.NW(DIV1_NW), .DW(DEN_W)) u_pdiv (
            .aclk (aclk),
            .en   (en),
            .num  (s0_pnum_reg[b]),
            .den  (s0_den_reg[b]),
            .quo  (p_quo[b])
        );
        rbf_div #(.NW(DIV1_NW), .DW(DEN_W)) u_qdiv (
            .aclk (aclk),
            .en   (en),
            .num  (s0_qnum_reg[b]),
            .den  (s0_den_reg[b]),
            .quo  (q_quo[b])
        );
    end

    // Rate difference and valid bits ride alongside the first divider.
    logic [DIV1_NW-1:0]       dl1_valid_reg;
    logic signed [DIFF_W-1:0] dl1_diff_reg [DIV1_NW];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl1_diff_reg[0] <= s0_diff_reg;
            for (int i = 1; i < DIV1_NW; i++) begin
                dl1_diff_reg[i] <= dl1_diff_reg[i-1];
            end
        end
    end

    // Term products: T = p_hi*q + (p_lo*q >> 32).
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_diff_reg;
    logic [PROD_W-1:0]        a_hi_reg [NBUF];
    logic [PROD_W-1:0]        a_lo_reg [NBUF];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_diff_reg <= dl1_diff_reg[DIV1_NW-1];
            for (int b = 0; b < NBUF; b++) begin
                a_hi_reg[b] <= p_quo[b][DIV1_NW-1:CONC_W] * q_quo[b][DEN_W-1:0];
                a_lo_reg[b] <= p_quo[b][CONC_W-1:0] * q_quo[b][DEN_W-1:0];
            end
        end
    end

    logic                     b_valid_reg;
    logic signed [DIFF_W-1:0] b_diff_reg;
    logic [TERM_W-1:0]        b_term_reg [NBUF];

    always_ff @(posedge aclk) begin
        if (en) begin
            b_diff_reg <= a_diff_reg;
            for (int b = 0; b < NBUF; b++) begin
                logic [TERM_W-1:0] t;
                t = {1'b0, a_hi_reg[b][TERM_W-2:0]}
                    + TERM_W'(a_lo_reg[b][PROD_W-1:CONC_W]);
                if (a_hi_reg[b] >= PROD_W'(SUM_LIMIT) || t > SUM_LIMIT) begin
                    b_term_reg[b] <= SUM_LIMIT;
                end else begin
                    b_term_reg[b] <= t;
                end
            end
        end
    end

    logic                     c_valid_reg;
    logic signed [DIFF_W-1:0] c_diff_reg;
    logic [TERM_W-1:0]        c_sum_reg;
    logic [TERM_W+1:0]        c_total;

    assign c_total = (TERM_W+2)'(b_term_reg[0]) + (TERM_W+2)'(b_term_reg[1])
                   + (TERM_W+2)'(b_term_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            c_diff_reg <= b_diff_reg;
            c_sum_reg  <= (c_total > (TERM_W+2)'(SUM_LIMIT)) ? SUM_LIMIT
                                                             : c_total[TERM_W-1:0];
        end
    end

    // beta = round(2^56 / (2^32 + S)); the magnitude of the difference is
    // taken here so the multiply stage sees a plain unsigned product.
    logic                    d_valid_reg;
    logic [BDEN_W-1:0]       d_den_reg;
    logic [BNUM_W-1:0]       d_num_reg;
    logic [DIFF_W-1:0]       d_mag_reg;
    logic                    d_neg_reg;
    logic [BDEN_W-1:0]       d_den;

    assign d_den = ONE_Q32 + c_sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_den_reg <= d_den;
            d_num_reg <= ONE_Q56 + d_den[BDEN_W-1:1];
            d_neg_reg <= c_diff_reg[DIFF_W-1];
            d_mag_reg <= c_diff_reg[DIFF_W-1] ? DIFF_W'(-c_diff_reg) : DIFF_W'(c_diff_reg);
        end
    end

    logic [BNUM_W-1:0] beta_quo;

    rbf_div #(.NW(BNUM_W), .DW(BDEN_W)) u_beta_div (
        .aclk (aclk),
        .en   (en),
        .num  (d_num_reg),
        .den  (d_den_reg),
        .quo  (beta_quo)
    );

    logic [BNUM_W-1:0] dl2_valid_reg;
    logic [DIFF_W-1:0] dl2_mag_reg [BNUM_W];
    logic [BNUM_W-1:0] dl2_neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dl2_mag_reg[0] <= d_mag_reg;
            for (int i = 1; i < BNUM_W; i++) begin
                dl2_mag_reg[i] <= dl2_mag_reg[i-1];
            end
            dl2_neg_reg <= {dl2_neg_reg[BNUM_W-2:0], d_neg_reg};
        end
    end

    logic                 e_valid_reg;
    logic [BETA_W-1:0]    e_beta_reg;
    logic [FPROD_W-1:0]   e_prod_reg;
    logic                 e_neg_reg;
    logic [BETA_W-1:0]    e_beta;

    assign e_beta = beta_quo[BETA_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            e_beta_reg <= e_beta;
            e_prod_reg <= (ONE_Q24 - e_beta) * dl2_mag_reg[BNUM_W-1];
            e_neg_reg  <= dl2_neg_reg[BNUM_W-1];
        end
    end

    // Round half away from zero, then saturate to the signed 32-bit range.
    logic              f_valid_reg;
    out_t              f_data_reg;
    logic [FQ_W-1:0]   f_q;
    logic [FPROD_W-1:0] f_round;

    assign f_round = e_prod_reg + HALF_Q24;
    assign f_q     = f_round[FPROD_W-1:24];

    always_ff @(posedge aclk) begin
        if (en) begin
            f_data_reg.beta_factor <= e_beta_reg;
            if (e_neg_reg) begin
                f_data_reg.buffer_flux <= (f_q > NEG_MAX) ? RATE_W'(NEG_MAX)
                                                          : RATE_W'(-f_q);
            end else begin
                f_data_reg.buffer_flux <= (f_q > POS_MAX) ? RATE_W'(POS_MAX)
                                                          : RATE_W'(f_q);
            end
        end
    end

    // Valid chain of the whole pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg  <= 1'b0;
            dl1_valid_reg <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            dl2_valid_reg <= '0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
        end else if (en) begin
            s0_valid_reg  <= s_valid;
            dl1_valid_reg <= {dl1_valid_reg[DIV1_NW-2:0], s0_valid_reg};
            a_valid_reg   <= dl1_valid_reg[DIV1_NW-1];
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            dl2_valid_reg <= {dl2_valid_reg[BNUM_W-2:0], d_valid_reg};
            e_valid_reg   <= dl2_valid_reg[BNUM_W-1];
            f_valid_reg   <= e_valid_reg;
        end
    end

    // Output register with a skid entry. The pipeline freezes only while the
    // skid entry is occupied.
    logic m_valid_reg;
    out_t m_data_reg;
    out_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= f_valid_reg;
            end
        end else if (f_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !m_valid_reg) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : f_data_reg;
        end else if (f_valid_reg && !skid_valid_reg) begin
            skid_data_reg <= f_data_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/rbf_checker.sv =====
`include "rapid_buffer_flux_assert.svh"

module rbf_checker
    import rbf_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A stalled result transfer keeps its payload.
    `RBF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    `RBF_ASSERT_IMPL(a_beta_range, m_valid, m_data.beta_factor <= ONE_Q24)

    // With no buffering at all the flux must vanish.
    `RBF_ASSERT_IMPL(a_unbuffered_zero, m_valid && (m_data.beta_factor == ONE_Q24), m_data.buffer_flux == '0)

    // The input side only stalls when results are backed up behind the output.
    `RBF_ASSERT_IMPL(a_stall_cause, !s_ready, m_valid)

endmodule

bind rapid_buffer_flux rbf_checker u_rbf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/rapid_buffer_flux_tb.sv =====
module rapid_buffer_flux_tb;
    import rbf_pkg::*;

    localparam int PIPE_LAT = 140;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS = 400;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CONC_W-1:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    rapid_buffer_flux dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the six buffer registers, ordered by register index.
    logic [CONC_W-1:0] buf_regs [6];
    out_t flux_queue [$];
    int errors = 0;
    int cycles = 0;
    int results_seen = 0;
    int items_sent = 0;
    bit hold_off = 1'b0;
    bit long_stall = 1'b0;
    bit rx_done_stall = 1'b0;

    function automatic logic [63:0] binding_term(logic [31:0] total, logic [31:0] kd,
                                                 logic [31:0] conc);
        logic [63:0] den, p, q, hi, lo, t;
        den = {32'd0, conc} + {32'd0, kd};
        if (den == 0)
            return 64'd0;
        p = {total, 32'd0} / den;
        q = {kd, 32'd0} / den;
        hi = (p >> 32) * q;
        if (hi >= SUM_LIMIT)
            return 64'(SUM_LIMIT);
        lo = ({32'd0, p[31:0]} * q) >> 32;
        t = hi + lo;
        return (t > SUM_LIMIT) ? 64'(SUM_LIMIT) : t;
    endfunction

    function automatic out_t predict_flux(in_t item);
        logic [63:0] sum, den, beta, frac, mag, q;
        logic signed [63:0] diff;
        out_t res;
        sum = binding_term(buf_regs[REG_LOW_TOTAL], buf_regs[REG_LOW_KD], item.calcium_conc)
            + binding_term(buf_regs[REG_HIGH_TOTAL], buf_regs[REG_HIGH_KD], item.calcium_conc)
            + binding_term(buf_regs[REG_CYTO_TOTAL], buf_regs[REG_CYTO_KD], item.calcium_conc);
        if (sum > SUM_LIMIT)
            sum = 64'(SUM_LIMIT);
        den = 64'h1_0000_0000 + sum;
        beta = ((64'd1 << 56) + (den >> 1)) / den;
        if (beta > ONE_Q24)
            beta = 64'(ONE_Q24);
        frac = 64'(ONE_Q24) - beta;
        diff = 64'(item.calcium_rate) - 64'(item.bound_rate);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        q = (frac * mag + (64'd1 << 23)) >> 24;
        if (diff < 0)
            res.buffer_flux = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        else
            res.buffer_flux = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
        res.beta_factor = beta[BETA_W-1:0];
        return res;
    endfunction

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CONC_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < 6)
            buf_regs[idx] = val;
        @(posedge aclk);
    endtask

    // Waits for all outstanding results, then lets the pipeline drain fully.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (flux_queue.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    // Valid stays high between back-to-back items and drops only for a gap.
    task automatic send_item(in_t item, int gap, bit check_fixed, out_t fixed);
        out_t exp_res;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        exp_res = predict_flux(item);
        if (check_fixed && exp_res !== fixed) begin
            $error("directed row: predictor gives %h, table says %h", exp_res, fixed);
            errors++;
        end
        s_valid <= 1'b1;
        s_data <= item;
        flux_queue.push_back(exp_res);
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_conc();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0400_0000);
            2: return $urandom_range(0, 255);
            default: return $urandom_range(32'h0010_0000, 32'h0200_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_reg(bit is_kd);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h1000_0000);
            2: v = $urandom_range(0, 255);
            default: v = $urandom_range(32'h0008_0000, 32'h0400_0000);
        endcase
        if (is_kd && v == 0)
            v = 1;
        return v;
    endfunction

    typedef struct {
        in_t item;
        bit check_fixed;
        out_t fixed;
    } stim_row_t;

    // Result side: random stalls, plus one long hold-off driven from the sender.
    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_stall) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_stall = 1'b0;
            end
            wait_cycles = hold_off ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0)
                wait_cycles = 0;
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Checks each transfer on the result side against the oldest expectation.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (flux_queue.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_data);
                errors++;
            end else begin
                out_t exp_res;
                exp_res = flux_queue.pop_front();
                if (m_data.buffer_flux !== exp_res.buffer_flux) begin
                    $error("buffer_flux: expected %0d, got %0d",
                           exp_res.buffer_flux, m_data.buffer_flux);
                    errors++;
                end
                if (m_data.beta_factor !== exp_res.beta_factor) begin
                    $error("beta_factor: expected %0d, got %0d",
                           exp_res.beta_factor, m_data.beta_factor);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rapid_buffer_flux_tb: done, errors");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        stim_row_t row;
        in_t item;
        int phase;
        buf_regs[0] = 0; buf_regs[1] = KD_RESET; buf_regs[2] = 0;
        buf_regs[3] = KD_RESET; buf_regs[4] = 0; buf_regs[5] = KD_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With no buffers loaded beta is exactly one and the flux is zero.
        row = '{'{32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1, '{32'sd0, ONE_Q24}};
        rows.push_back(row);
        row = '{'{32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b1, '{32'sd0, ONE_Q24}};
        rows.push_back(row);
        row = '{'{32'h0100_0000, 32'sd65536, 32'sd0}, 1'b1, '{32'sd0, ONE_Q24}};
        rows.push_back(row);
        foreach (rows[i])
            send_item(rows[i].item, 0, rows[i].check_fixed, rows[i].fixed);
        drain_pipe();

        // Saturated buffering sum: beta reaches zero, full rate difference saturates.
        write_reg(REG_LOW_TOTAL, 32'hFFFF_FFFF);
        write_reg(REG_LOW_KD, 32'd1);
        write_reg(REG_UNUSED, 32'h1234_5678);
        rows.delete();
        row = '{'{32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1, '{32'sh7FFF_FFFF, 25'd0}};
        rows.push_back(row);
        row = '{'{32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b1, '{32'sh8000_0000, 25'd0}};
        rows.push_back(row);
        row = '{'{32'd0, 32'sd100, 32'sd0}, 1'b1, '{32'sd100, 25'd0}};
        rows.push_back(row);
        row = '{'{32'hFFFF_FFFF, 32'sd12345, 32'sd0}, 1'b0, '0};
        rows.push_back(row);
        foreach (rows[i])
            send_item(rows[i].item, 0, rows[i].check_fixed, rows[i].fixed);
        drain_pipe();

        // Zero Kd with zero calcium drops that buffer's contribution.
        write_reg(REG_HIGH_TOTAL, 32'h0100_0000);
        write_reg(REG_HIGH_KD, 32'd0);
        write_reg(REG_CYTO_TOTAL, 32'h0080_0000);
        write_reg(REG_CYTO_KD, 32'h0040_0000);
        write_reg(REG_LOW_TOTAL, 32'h0200_0000);
        write_reg(REG_LOW_KD, 32'h0100_0000);
        rows.delete();
        for (int i = 0; i < 12; i++) begin
            row.item.calcium_conc = (i < 2) ? 32'd0 : rand_conc();
            row.item.calcium_rate = (i == 2) ? 32'sh7FFF_FFFF : $urandom();
            row.item.bound_rate = (i == 2) ? 32'sh8000_0000 : $urandom();
            row.check_fixed = 1'b0;
            rows.push_back(row);
        end
        foreach (rows[i])
            send_item(rows[i].item, 0, rows[i].check_fixed, rows[i].fixed);
        drain_pipe();

        // Random phases, each with a fresh register setting.
        for (phase = 0; phase < 8; phase++) begin
            for (int r = 0; r < 6; r++)
                write_reg(r[CFG_AW-1:0], rand_reg(r % 2 == 1));
            if (phase == 7)
                for (int r = 0; r < 6; r++)
                    write_reg(r[CFG_AW-1:0], (r % 2 == 1) ? 32'hFFFF_FFFF : 32'h0);
            hold_off = (phase == 3);
            if (phase == 2)
                long_stall = 1'b1;
            for (int i = 0; i < RAND_ITEMS / 8; i++) begin
                item.calcium_conc = rand_conc();
                item.calcium_rate = $urandom();
                item.bound_rate = $urandom();
                if ($urandom_range(0, 3) == 0)
                    item.bound_rate = item.calcium_rate - $urandom_range(0, 2000) + 1000;
                send_item(item, (phase == 2 || phase == 3 || $urandom_range(0, 2) == 0)
                          ? 0 : $urandom_range(0, 14), 1'b0, '0);
            end
            // The sender waits for every outstanding result between phases.
            drain_pipe();
        end

        $display("Sent %0d items over 11 register settings, %0d results checked.",
                 items_sent, results_seen);
        if (errors == 0)
            $display("rapid_buffer_flux_tb: done, clean");
        else
            $display("rapid_buffer_flux_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rbf_pkg.sv
src/rbf_div.sv
src/rapid_buffer_flux.sv
src/rbf_checker.sv
tb/sv/rapid_buffer_flux_tb.sv
